### rtl/clns_pkg.sv
package clns_pkg;

  typedef enum logic [2:0] {
    CMD_INSTR = 3'd0,
    CMD_CHAR  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_GOTO  = 3'd3,
    CMD_HEX   = 3'd4,
    CMD_INIT  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_HEX  = 2'd1,
    KIND_INIT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       rs;
    logic       long_wait;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        rs;
    logic        strobe;
    logic [15:0] wait_us;
    logic        last;
  } res_t;

  localparam int FIFO_DEPTH = 2;

  localparam logic [7:0]  CLEAR_BYTE = 8'h01;
  localparam logic [7:0]  GOTO_BASE  = 8'h80;
  localparam logic [15:0] WAIT_NIB   = 16'd2;
  localparam logic [15:0] WAIT_CMD   = 16'd50;
  localparam logic [15:0] WAIT_CLEAR = 16'd2050;
  localparam logic [15:0] WAIT_POWER = 16'd60000;
  localparam logic [15:0] WAIT_WAKE  = 16'd10000;
  localparam logic [4:0]  LAST_BYTE  = 5'd1;
  localparam logic [4:0]  LAST_HEX   = 5'd3;
  localparam logic [4:0]  LAST_INIT  = 5'd22;
  localparam logic [4:0]  INIT_RAW   = 5'd5;

  function automatic logic [7:0] init_byte(input logic profile, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h29;
      4'd1:    b = profile ? 8'h1F : 8'h1D;
      4'd2:    b = 8'h79;
      4'd3:    b = profile ? 8'h54 : 8'h50;
      4'd4:    b = profile ? 8'h6E : 8'h6C;
      4'd5:    b = 8'h28;
      4'd6:    b = profile ? 8'h0F : 8'h0E;
      4'd7:    b = 8'h01;
      4'd8:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] d);
    return (d > 4'd9) ? (8'h37 + {4'h0, d}) : (8'h30 + {4'h0, d});
  endfunction

endpackage

### rtl/clns_front.sv
module clns_front (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,
  input  logic             push_ready_i,
  output logic             push_valid_o,
  output clns_pkg::op_t    op_o
);

  logic [2:0] cmd;
  logic [7:0] value;
  logic       known;

  assign cmd   = s_axis_tdata[2:0];
  assign value = s_axis_tdata[10:3];

  always_comb begin
    known        = 1'b1;
    op_o.kind    = clns_pkg::KIND_BYTE;
    op_o.rs      = 1'b0;
    op_o.long_wait = 1'b0;
    op_o.data    = value;
    unique case (cmd)
      clns_pkg::CMD_INSTR: begin
      end
      clns_pkg::CMD_CHAR: begin
        op_o.rs = 1'b1;
      end
      clns_pkg::CMD_CLEAR: begin
        op_o.long_wait = 1'b1;
        op_o.data      = clns_pkg::CLEAR_BYTE;
      end
      clns_pkg::CMD_GOTO: begin
        op_o.data = clns_pkg::GOTO_BASE + value;
      end
      clns_pkg::CMD_HEX: begin
        op_o.kind = clns_pkg::KIND_HEX;
        op_o.rs   = 1'b1;
      end
      clns_pkg::CMD_INIT: begin
        op_o.kind = clns_pkg::KIND_INIT;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown command codes are taken off the bus and dropped.
  assign s_axis_tready = push_ready_i;
  assign push_valid_o  = s_axis_tvalid & known;

endmodule

### rtl/clns_fifo.sv
module clns_fifo #(
  parameter int Depth = clns_pkg::FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          ready_o,
  input  clns_pkg::op_t op_i,
  input  logic          pop_i,
  output logic          valid_o,
  output clns_pkg::op_t op_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  clns_pkg::op_t mem [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = count_q != CntW'(Depth);
  assign valid_o = count_q != '0;
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;
  assign op_o    = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= op_i;
    end
  end

endmodule

### rtl/clns_back.sv
module clns_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          profile_i,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  input  clns_pkg::op_t op_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [23:0]   m_axis_tdata,
  output logic [1:0]    m_axis_tuser,
  output logic          m_axis_tlast
);

  clns_pkg::op_t  op_q;
  logic           busy_q, busy_d;
  logic [4:0]     step_q, step_d;
  logic           out_valid_q, out_valid_d;
  clns_pkg::res_t out_q;
  clns_pkg::res_t gen;
  logic           can_load;
  logic           load_out;
  logic [7:0]     cur_byte;
  logic           half;
  logic [4:0]     init_ofs;
  logic [15:0]    tail;

  assign can_load = !out_valid_q || m_axis_tready;
  assign load_out = busy_q && can_load;
  assign op_pop_o = !busy_q && op_valid_i;

  always_comb begin
    init_ofs   = step_q - clns_pkg::INIT_RAW;
    tail       = op_q.long_wait ? clns_pkg::WAIT_CLEAR : clns_pkg::WAIT_CMD;
    cur_byte   = op_q.data;
    half       = step_q[0];
    gen.rs     = op_q.rs;
    gen.strobe = 1'b1;
    gen.last   = 1'b0;
    unique case (op_q.kind)
      clns_pkg::KIND_BYTE: begin
        gen.last = step_q == clns_pkg::LAST_BYTE;
      end
      clns_pkg::KIND_HEX: begin
        cur_byte = clns_pkg::hex_ascii(step_q[1] ? op_q.data[3:0] : op_q.data[7:4]);
        gen.last = step_q == clns_pkg::LAST_HEX;
      end
      clns_pkg::KIND_INIT: begin
        cur_byte = clns_pkg::init_byte(profile_i, init_ofs[4:1]);
        half     = init_ofs[0];
        gen.last = step_q == clns_pkg::LAST_INIT;
      end
      default: begin
      end
    endcase
    gen.nibble  = half ? cur_byte[3:0] : cur_byte[7:4];
    gen.wait_us = half ? tail : clns_pkg::WAIT_NIB;
    // The power-on wait and the raw wake-up nibbles precede the init bytes.
    if (op_q.kind == clns_pkg::KIND_INIT && step_q < clns_pkg::INIT_RAW) begin
      case (step_q)
        5'd0: begin
          gen.nibble  = 4'h0;
          gen.strobe  = 1'b0;
          gen.wait_us = clns_pkg::WAIT_POWER;
        end
        5'd1: begin
          gen.nibble  = 4'h3;
          gen.wait_us = clns_pkg::WAIT_WAKE;
        end
        5'd4: begin
          gen.nibble  = 4'h2;
          gen.wait_us = clns_pkg::WAIT_CMD;
        end
        default: begin
          gen.nibble  = 4'h3;
          gen.wait_us = clns_pkg::WAIT_CMD;
        end
      endcase
    end
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
      if (gen.last) begin
        busy_d = 1'b0;
        step_d = '0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (op_pop_o) begin
      busy_d = 1'b1;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
    if (load_out) begin
      out_q <= gen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_q.wait_us, out_q.nibble};
  assign m_axis_tuser  = {out_q.strobe, out_q.rs};
  assign m_axis_tlast  = out_q.last;

endmodule

### rtl/char_lcd_nibble_sequencer.sv
// Expands character LCD requests into 4-bit bus transfers, each with its wait in
// microseconds. A byte request yields 2 transfers, a hex byte 4 and init 23; the
// sequencer emits one transfer per cycle when the output is taken, and fetches the
// next request from the queue only once the last transfer of the current one is
// loaded. The input side takes a new request whenever the request queue has room,
// and unknown command codes are consumed without any output. The init profile is
// sampled while the init sequence runs and should be written only when idle.
module char_lcd_nibble_sequencer #(
  parameter int FifoDepth = clns_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // init_profile
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd[2:0], value[10:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // nibble[3:0], wait_us[19:4]
  output logic [1:0]  m_axis_tuser,   // reg_select[0], strobe_res[1]
  output logic        m_axis_tlast
);

  logic          profile_q;
  logic          push_valid, push_ready;
  logic          pop, q_valid;
  clns_pkg::op_t front_op, q_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      profile_q <= 1'b0;
    end else if (cfg_valid_i) begin
      profile_q <= cfg_data_i;
    end
  end

  clns_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .op_o          (front_op)
  );

  clns_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .ready_o (push_ready),
    .op_i    (front_op),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  clns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .profile_i     (profile_q),
    .op_valid_i    (q_valid),
    .op_pop_o      (pop),
    .op_i          (q_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/clns_checker.sv
module clns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled transfer keeps its valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A pure wait is only the power-on wait of init and is never the last transfer.
  a_pure_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |->
      m_axis_tdata[3:0] == 4'h0 && m_axis_tdata[19:4] == 16'd60000 && !m_axis_tlast)
    else $error("malformed pure wait");

  // Data register transfers only use the short or the ordinary wait.
  a_data_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[19:4] == 16'd2 || m_axis_tdata[19:4] == 16'd50)
    else $error("bad wait on a data transfer");

  // A last transfer always closes a byte, so it never carries the short wait.
  a_last_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[19:4] != 16'd2)
    else $error("request ended on a high nibble");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
